>>> sv/huffman_code_length_builder_defines.svh
// assertion macros used by the huffman code length builder datapath
// no dependencies; each file that asserts includes this header
`ifndef HUFFMAN_CODE_LENGTH_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_LENGTH_BUILDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HCL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HCL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hcl_pkg.sv
// shared types and constants of the huffman code length builder
// no dependencies; used by the controller, datapath and top level
package hcl_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int SYM_W            = 8;
    localparam int OCC_W            = 32;
    localparam int LEN_W            = 8;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_BUILD = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    typedef struct packed {
        func_t              func;
        logic [SYM_W-1:0]   symbol;
        logic [OCC_W-1:0]   occurrences;
    } req_item_t;

    typedef struct packed {
        logic               status;
        logic               present;
        logic [LEN_W-1:0]   code_length;
    } rsp_item_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_QUERY,
        OUT_BUILD
    } out_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Q_OUT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_NEXT_SYM,
        ST_INS_RD,
        ST_INS_CMP,
        ST_MERGE_CHK,
        ST_POP_A,
        ST_POP_B,
        ST_POP_L,
        ST_POP_W,
        ST_ROOT_RD,
        ST_ROOT_LAT,
        ST_DEP_CHK,
        ST_DEP_PAR,
        ST_DEP_WR,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic     do_clear;
        logic     do_load;
        logic     do_query;
        logic     build_init;
        logic     scan_rd;
        logic     scan_take;
        logic     sym_inc;
        logic     ins_rd;
        logic     ins_shift;
        logic     ins_place;
        logic     pop_a;
        logic     pop_b;
        logic     pop_l;
        logic     pop_w;
        logic     root_rd;
        logic     root_lat;
        logic     k_dec;
        logic     dep_par_rd;
        logic     dep_dep_rd;
        logic     dep_wr;
        logic     out_load;
        out_sel_t out_sel;
    } hcl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic nz_s;
        logic sym_last;
        logic ins_at_head;
        logic ins_greater;
        logic len_zero;
        logic len_one;
        logic root_zero;
        logic k_zero;
        logic k_skip;
    } hcl_stat_t;

endpackage

>>> sv/hcl_ctrl.sv
// sequencer of the huffman code length builder
// depends on hcl_pkg; drives the datapath through hcl_cmd_t
module hcl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  hcl_pkg::func_t    req_func,
    output logic              req_ready,
    input  hcl_pkg::hcl_stat_t stat,
    output hcl_pkg::hcl_cmd_t cmd
);
    import hcl_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        scan_phase_reg, scan_phase_next;
    logic        accept;

    assign req_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_phase_reg <= scan_phase_next;
        end
    end

    // next state
    always_comb
    begin
        state_next      = state_reg;
        scan_phase_next = scan_phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_func == FUNC_QUERY)
                        state_next = ST_Q_OUT;
                    else if (req_func == FUNC_BUILD)
                    begin
                        state_next      = ST_SCAN_RD;
                        scan_phase_next = 1'b1;
                    end
                end
            end
            ST_Q_OUT:
                if (stat.out_free) state_next = ST_IDLE;
            ST_SCAN_RD:
                state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
                state_next = stat.nz_s ? ST_INS_RD : ST_NEXT_SYM;
            ST_NEXT_SYM:
            begin
                if (stat.sym_last)
                begin
                    state_next      = ST_MERGE_CHK;
                    scan_phase_next = 1'b0;
                end
                else
                    state_next = ST_SCAN_RD;
            end
            ST_INS_RD:
            begin
                if (stat.ins_at_head)
                    state_next = scan_phase_reg ? ST_NEXT_SYM : ST_MERGE_CHK;
                else
                    state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if (stat.ins_greater)
                    state_next = ST_INS_RD;
                else
                    state_next = scan_phase_reg ? ST_NEXT_SYM : ST_MERGE_CHK;
            end
            ST_MERGE_CHK:
            begin
                if (stat.len_zero)
                    state_next = ST_FINISH;
                else if (stat.len_one)
                    state_next = ST_ROOT_RD;
                else
                    state_next = ST_POP_A;
            end
            ST_POP_A:    state_next = ST_POP_B;
            ST_POP_B:    state_next = ST_POP_L;
            ST_POP_L:    state_next = ST_POP_W;
            ST_POP_W:    state_next = ST_INS_RD;
            ST_ROOT_RD:  state_next = ST_ROOT_LAT;
            ST_ROOT_LAT: state_next = stat.root_zero ? ST_FINISH : ST_DEP_CHK;
            ST_DEP_CHK:
            begin
                if (!stat.k_skip)
                    state_next = ST_DEP_PAR;
                else if (stat.k_zero)
                    state_next = ST_FINISH;
            end
            ST_DEP_PAR:  state_next = ST_DEP_WR;
            ST_DEP_WR:   state_next = stat.k_zero ? ST_FINISH : ST_DEP_CHK;
            ST_FINISH:
                if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        cmd.out_sel = OUT_ZERO;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_func)
                        FUNC_CLEAR:
                        begin
                            cmd.do_clear = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        FUNC_LOAD:
                        begin
                            cmd.do_load  = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        FUNC_QUERY: cmd.do_query   = 1'b1;
                        FUNC_BUILD: cmd.build_init = 1'b1;
                        default:    cmd.out_load   = 1'b1;
                    endcase
                end
            end
            ST_Q_OUT:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_QUERY;
            end
            ST_SCAN_RD:  cmd.scan_rd   = 1'b1;
            ST_SCAN_CHK: cmd.scan_take = stat.nz_s;
            ST_NEXT_SYM: cmd.sym_inc   = !stat.sym_last;
            ST_INS_RD:
            begin
                cmd.ins_place = stat.ins_at_head;
                cmd.ins_rd    = !stat.ins_at_head;
            end
            ST_INS_CMP:
            begin
                cmd.ins_shift = stat.ins_greater;
                cmd.ins_place = !stat.ins_greater;
            end
            ST_POP_A:    cmd.pop_a    = 1'b1;
            ST_POP_B:    cmd.pop_b    = 1'b1;
            ST_POP_L:    cmd.pop_l    = 1'b1;
            ST_POP_W:    cmd.pop_w    = 1'b1;
            ST_ROOT_RD:  cmd.root_rd  = 1'b1;
            ST_ROOT_LAT: cmd.root_lat = 1'b1;
            ST_DEP_CHK:
            begin
                cmd.dep_par_rd = !stat.k_skip;
                cmd.k_dec      = stat.k_skip && !stat.k_zero;
            end
            ST_DEP_PAR:  cmd.dep_dep_rd = 1'b1;
            ST_DEP_WR:
            begin
                cmd.dep_wr = 1'b1;
                cmd.k_dec  = !stat.k_zero;
            end
            ST_FINISH:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_sel  = OUT_BUILD;
            end
            default:     cmd = '0;
        endcase
    end

endmodule

>>> sv/hcl_datapath.sv
// memories, counters and result register of the huffman code length builder
// depends on hcl_pkg and huffman_code_length_builder_defines.svh
`include "huffman_code_length_builder_defines.svh"

module hcl_datapath #(
    parameter int SYMBOL_COUNT = hcl_pkg::SYMBOL_COUNT_DEF,
    parameter int COUNT_BITS   = hcl_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hcl_pkg::req_item_t  req_item,
    input  hcl_pkg::hcl_cmd_t   cmd,
    output hcl_pkg::hcl_stat_t  stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output hcl_pkg::rsp_item_t  rsp_item
);
    import hcl_pkg::*;

    localparam int SYM_BITS    = $clog2(SYMBOL_COUNT);
    localparam int NODE_BITS   = $clog2(2 * SYMBOL_COUNT);
    localparam int WL_DEPTH    = 2 * SYMBOL_COUNT;
    localparam int NODE_DEPTH  = 2 * SYMBOL_COUNT - 1;
    localparam int WEIGHT_BITS = COUNT_BITS + SYM_BITS;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] weight;
        logic [NODE_BITS-1:0]   node;
    } entry_t;

    // storage
    logic [COUNT_BITS-1:0] count_mem [SYMBOL_COUNT];
    entry_t                wl_mem    [WL_DEPTH];
    logic [NODE_BITS-1:0]  par_mem   [NODE_DEPTH];
    logic [LEN_W-1:0]      dep_mem   [NODE_DEPTH];

    logic [COUNT_BITS-1:0] count_rd_reg;
    entry_t                wl_rd_reg;
    logic [NODE_BITS-1:0]  par_rd_reg;
    logic [LEN_W-1:0]      dep_rd_reg;

    logic [SYMBOL_COUNT-1:0] nz_reg, leaf_reg;
    logic                    built_reg;
    logic [SYM_BITS-1:0]     sym_reg;
    logic [NODE_BITS-1:0]    head_reg, tail_reg, i_reg, next_node_reg, k_reg;
    logic [WEIGHT_BITS-1:0]  ins_w_reg;
    logic [NODE_BITS-1:0]    ins_node_reg;
    entry_t                  a_reg;
    logic                    q_hit_reg;
    logic                    rsp_valid_reg;
    rsp_item_t               rsp_item_reg;

    // request decode
    logic                  in_range;
    logic [SYM_BITS-1:0]   req_idx;
    logic [COUNT_BITS-1:0] occ;

    assign in_range = {1'b0, req_item.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign req_idx  = req_item.symbol[SYM_BITS-1:0];
    assign occ      = COUNT_BITS'(req_item.occurrences);

    // address and data selection
    logic                 wl_ren, wl_wen, dep_ren, dep_wen, par_wen;
    logic [NODE_BITS-1:0] wl_raddr, wl_waddr, dep_raddr, dep_waddr, par_waddr;
    entry_t               wl_wdata;
    logic [LEN_W-1:0]     dep_wdata;

    always_comb
    begin
        wl_ren   = cmd.ins_rd || cmd.pop_a || cmd.pop_b || cmd.root_rd;
        wl_raddr = head_reg;
        if (cmd.ins_rd)
            wl_raddr = i_reg - NODE_BITS'(1);
        else if (cmd.pop_b)
            wl_raddr = head_reg + NODE_BITS'(1);

        wl_wen   = cmd.ins_shift || cmd.ins_place;
        wl_waddr = i_reg;
        wl_wdata = cmd.ins_shift ? wl_rd_reg : entry_t'({ins_w_reg, ins_node_reg});

        par_wen   = cmd.pop_l || cmd.pop_w;
        par_waddr = cmd.pop_l ? a_reg.node : wl_rd_reg.node;

        dep_ren   = cmd.do_query || cmd.dep_dep_rd;
        dep_raddr = cmd.do_query ? NODE_BITS'(req_idx) : par_rd_reg;
        dep_wen   = cmd.root_lat || cmd.dep_wr;
        dep_waddr = cmd.root_lat ? wl_rd_reg.node : k_reg;
        dep_wdata = cmd.root_lat ? '0 : dep_rd_reg + LEN_W'(1);
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && in_range)
            count_mem[req_idx] <= occ;
        if (cmd.scan_rd)
            count_rd_reg <= count_mem[sym_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wl_wen)
            wl_mem[wl_waddr] <= wl_wdata;
        if (wl_ren)
            wl_rd_reg <= wl_mem[wl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (par_wen)
            par_mem[par_waddr] <= next_node_reg;
        if (cmd.dep_par_rd)
            par_rd_reg <= par_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dep_wen)
            dep_mem[dep_waddr] <= dep_wdata;
        if (dep_ren)
            dep_rd_reg <= dep_mem[dep_raddr];
    end

    // payload registers of the scan insertion and merge walks
    always_ff @(posedge clk)
    begin
        if (cmd.scan_take)
        begin
            ins_w_reg    <= WEIGHT_BITS'(count_rd_reg);
            ins_node_reg <= NODE_BITS'(sym_reg);
        end
        else if (cmd.pop_w)
        begin
            ins_w_reg    <= a_reg.weight + wl_rd_reg.weight;
            ins_node_reg <= next_node_reg;
        end
        if (cmd.pop_b)
            a_reg <= wl_rd_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= '0;
            leaf_reg      <= '0;
            built_reg     <= 1'b0;
            sym_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            i_reg         <= '0;
            next_node_reg <= '0;
            k_reg         <= '0;
            q_hit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
            begin
                nz_reg    <= '0;
                leaf_reg  <= '0;
                built_reg <= 1'b0;
            end
            if (cmd.do_load && in_range)
                nz_reg[req_idx] <= (occ != '0);
            if (cmd.do_query)
                q_hit_reg <= in_range && built_reg && leaf_reg[req_idx];
            if (cmd.build_init)
            begin
                leaf_reg      <= nz_reg;
                built_reg     <= 1'b0;
                sym_reg       <= '0;
                head_reg      <= '0;
                tail_reg      <= '0;
                next_node_reg <= NODE_BITS'(SYMBOL_COUNT);
            end
            if (cmd.sym_inc)
                sym_reg <= sym_reg + SYM_BITS'(1);
            if (cmd.scan_take)
                i_reg <= tail_reg;
            if (cmd.ins_shift)
                i_reg <= i_reg - NODE_BITS'(1);
            if (cmd.ins_place)
                tail_reg <= tail_reg + NODE_BITS'(1);
            if (cmd.pop_w)
            begin
                head_reg      <= head_reg + NODE_BITS'(2);
                i_reg         <= tail_reg;
                next_node_reg <= next_node_reg + NODE_BITS'(1);
            end
            if (cmd.root_lat)
                k_reg <= wl_rd_reg.node - NODE_BITS'(1);
            if (cmd.k_dec)
                k_reg <= k_reg - NODE_BITS'(1);
            if (cmd.out_load && cmd.out_sel == OUT_BUILD)
                built_reg <= (tail_reg != head_reg);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_QUERY:
                    rsp_item_reg <= '{status:      1'b0,
                                      present:     q_hit_reg,
                                      code_length: q_hit_reg ? dep_rd_reg : LEN_W'(0)};
                OUT_BUILD:
                    rsp_item_reg <= '{status:      (tail_reg == head_reg),
                                      present:     1'b0,
                                      code_length: LEN_W'(0)};
                default:   rsp_item_reg <= '0;
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // status to the sequencer
    always_comb
    begin
        stat.out_free    = !rsp_valid_reg || rsp_ready;
        stat.nz_s        = nz_reg[sym_reg];
        stat.sym_last    = (sym_reg == SYM_BITS'(SYMBOL_COUNT - 1));
        stat.ins_at_head = (i_reg == head_reg);
        stat.ins_greater = (wl_rd_reg.weight > ins_w_reg);
        stat.len_zero    = (tail_reg == head_reg);
        stat.len_one     = (tail_reg == head_reg + NODE_BITS'(1));
        stat.root_zero   = (wl_rd_reg.node == '0);
        stat.k_zero      = (k_reg == '0);
        stat.k_skip      = (k_reg < NODE_BITS'(SYMBOL_COUNT)) && !leaf_reg[k_reg[SYM_BITS-1:0]];
    end

    `HCL_ASSERT_IMP(a_list_order, 1'b1, tail_reg >= head_reg, "work list tail below head")
    `HCL_ASSERT_IMP(a_out_slot, cmd.out_load, !rsp_valid_reg || rsp_ready,
                    "result overwritten before it was taken")
    `HCL_ASSERT_NXT(a_load_mark, cmd.do_load && in_range && (occ != '0),
                    nz_reg[$past(req_idx)], "loaded symbol not marked")
    `HCL_ASSERT_IMP(a_pop_len, cmd.pop_a, !stat.len_zero && !stat.len_one,
                    "merge with fewer than two entries")

endmodule

>>> sv/huffman_code_length_builder.sv
// huffman code length builder: request and result channels, sequencer and datapath
// depends on hcl_pkg, hcl_ctrl and hcl_datapath
//
// usage
// - request channel req_valid / req_ready / req_item carries one item of kind
//   clear, load, build or query; result channel rsp_valid / rsp_ready / rsp_item
//   returns exactly one item per request, in order
// - clear and load: result is registered and valid in the cycle after acceptance
// - query: the depth read is registered, then moved to the result register once free
// - build: scans every symbol, inserting each present one into the sorted work
//   list by moving larger entries up, then n-1 merges, each popping two entries
//   and inserting their new parent, then a top-down depth pass over the tree
//   nodes; the insertion walks over the work list memory dominate the build time
// - one item is in work at a time; the next request is taken once the result
//   register is free or being drained in the same cycle
// - reset clears the presence flags of the count table and of the last tree,
//   so no memory needs a clearing pass; the block is ready right after reset
// - a stalled receiver holds the result in its register and the block takes
//   no further request until that result is taken
module huffman_code_length_builder #(
    parameter int SYMBOL_COUNT = hcl_pkg::SYMBOL_COUNT_DEF,
    parameter int COUNT_BITS   = hcl_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  hcl_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output hcl_pkg::rsp_item_t rsp_item
);
    import hcl_pkg::*;

    // command and status between sequencer and datapath
    hcl_cmd_t  cmd;
    hcl_stat_t stat;

    // sequencer: decodes the item kind and steps scan, merge and depth passes
    hcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_func  (req_item.func),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: count table, sorted work list, parent links, depths, result
    hcl_datapath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule
